FILE: design/mfs_pkg.sv
// mfs_pkg: shared types and constants for the max-frequency stack
// no dependencies; imported by mfs_cell and max_frequency_stack
`timescale 1ns / 1ps

package mfs_pkg;

    // default sizing for the parameters of the top level and mfs_cell
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_VALUE_BITS = 32;

    // fixed width of the value ports
    localparam int DATA_W = 32;

    // operation codes
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_opcode;

    // result status codes
    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // storage commands broadcast from the sequencer to every cell
    typedef struct packed {
        logic write;  // store key and level at the selected index
        logic shift;  // cells at or above the selected index take their neighbor
    } t_cell_ctl;

endpackage

FILE: design/mfs_cell.sv
// mfs_cell: one entry of the stack plus one stage of the search chain
// depends on mfs_pkg for the command struct
`timescale 1ns / 1ps

module mfs_cell
    import mfs_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int IDX_W     = $clog2(CAPACITY)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // broadcast from the sequencer
    input  t_cell_ctl             i_ctl,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [IDX_W-1:0]      i_sel_idx,
    input  logic [VALUE_BITS-1:0] i_key,
    input  logic [CNT_W-1:0]      i_wr_level,
    // contents of the next cell up, for the shift
    input  logic [VALUE_BITS-1:0] i_next_value,
    input  logic [CNT_W-1:0]      i_next_level,
    output logic [VALUE_BITS-1:0] o_value,
    output logic [CNT_W-1:0]      o_level,
    // search token from the previous cell
    input  logic                  i_car_valid,
    input  logic [CNT_W-1:0]      i_car_match,
    input  logic [CNT_W-1:0]      i_car_best_level,
    input  logic [IDX_W-1:0]      i_car_best_idx,
    input  logic [VALUE_BITS-1:0] i_car_best_value,
    // search token to the next cell
    output logic                  o_car_valid,
    output logic [CNT_W-1:0]      o_car_match,
    output logic [CNT_W-1:0]      o_car_best_level,
    output logic [IDX_W-1:0]      o_car_best_idx,
    output logic [VALUE_BITS-1:0] o_car_best_value
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [VALUE_BITS-1:0] r_value;
    logic [CNT_W-1:0]      r_level;
    logic                  r_car_valid;
    logic [CNT_W-1:0]      r_car_match;
    logic [CNT_W-1:0]      r_car_best_level;
    logic [IDX_W-1:0]      r_car_best_idx;
    logic [VALUE_BITS-1:0] r_car_best_value;

    logic w_in_use;
    logic w_match;
    logic w_better;

    // entry holds live data only below the fill count
    assign w_in_use = (CNT_W'(IDX) < i_count);
    assign w_match  = w_in_use && (r_value == i_key);
    // ties go to the later entry
    assign w_better = w_in_use && (r_level >= i_car_best_level);

    // entry storage: write on push, close the gap on pop
    always_ff @(posedge i_clk) begin
        if (i_ctl.write && (i_sel_idx == MY_IDX)) begin
            r_value <= i_key;
            r_level <= i_wr_level;
        end else if (i_ctl.shift && (MY_IDX >= i_sel_idx)) begin
            r_value <= i_next_value;
            r_level <= i_next_level;
        end
    end

    // token valid moves one cell per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car_valid <= 1'b0;
        end else begin
            r_car_valid <= i_car_valid;
        end
    end

    // token payload: match count and running maximum
    always_ff @(posedge i_clk) begin
        r_car_match <= w_match ? (i_car_match + CNT_W'(1)) : i_car_match;
        if (w_better) begin
            r_car_best_level <= r_level;
            r_car_best_idx   <= MY_IDX;
            r_car_best_value <= r_value;
        end else begin
            r_car_best_level <= i_car_best_level;
            r_car_best_idx   <= i_car_best_idx;
            r_car_best_value <= i_car_best_value;
        end
    end

    assign o_value          = r_value;
    assign o_level          = r_level;
    assign o_car_valid      = r_car_valid;
    assign o_car_match      = r_car_match;
    assign o_car_best_level = r_car_best_level;
    assign o_car_best_idx   = r_car_best_idx;
    assign o_car_best_value = r_car_best_value;

endmodule

FILE: design/max_frequency_stack.sv
// max_frequency_stack: top level, sequencer and the row of entry cells
// depends on mfs_pkg and mfs_cell
//
//  channel   ports                                   handshake
//  command   start, busy, i_opcode, i_push_value     taken when start & !busy
//  result    o_done, o_popped_value, o_status        o_done high for one cycle
//
// a push or pop on live data sends a search token down the CAPACITY cells,
// one cell per cycle, then applies the write or shift; no new command is
// accepted until then, as busy stays high through the sweep
// push when full and pop when empty finish without a sweep
// synchronous active-low reset empties the stack; the receiver cannot stall
`timescale 1ns / 1ps

module max_frequency_stack
    import mfs_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic                     i_opcode,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic                     busy,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_popped_value,
    output logic [1:0]               o_status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_SWEEP
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_count;
    logic [VALUE_BITS-1:0] r_key;
    t_opcode               r_op;
    logic                  r_launch;
    logic                  r_done;
    logic [DATA_W-1:0]     r_popped;
    t_status               r_status;

    // links along the chain
    logic                  w_car_valid      [0:CAPACITY];
    logic [CNT_W-1:0]      w_car_match      [0:CAPACITY];
    logic [CNT_W-1:0]      w_car_best_level [0:CAPACITY];
    logic [IDX_W-1:0]      w_car_best_idx   [0:CAPACITY];
    logic [VALUE_BITS-1:0] w_car_best_value [0:CAPACITY];
    logic [VALUE_BITS-1:0] w_value          [0:CAPACITY-1];
    logic [CNT_W-1:0]      w_level          [0:CAPACITY-1];

    logic [63:0]             w_push_ext;
    logic [VALUE_BITS-1:0]   w_push_key;
    logic [VALUE_BITS+31:0]  w_pop_ext;
    logic                    w_accept;
    logic                    w_full;
    logic                    w_empty;
    logic                    w_sweep_done;
    t_cell_ctl               w_ctl;
    logic [IDX_W-1:0]        w_sel_idx;
    logic [CNT_W-1:0]        w_wr_level;

    // values compare on their low VALUE_BITS bits
    assign w_push_ext = {32'b0, i_push_value};
    assign w_push_key = w_push_ext[VALUE_BITS-1:0];
    assign w_pop_ext  = {32'b0, w_car_best_value[CAPACITY]};

    assign w_accept     = start && (r_state == S_IDLE);
    assign w_full       = (r_count == CNT_W'(CAPACITY));
    assign w_empty      = (r_count == '0);
    assign w_sweep_done = (r_state == S_SWEEP) && w_car_valid[CAPACITY];

    // storage command once the token leaves the last cell
    always_comb begin
        w_ctl.write = w_sweep_done && (r_op == OP_PUSH);
        w_ctl.shift = w_sweep_done && (r_op == OP_POP);
        w_sel_idx   = (r_op == OP_PUSH) ? r_count[IDX_W-1:0] : w_car_best_idx[CAPACITY];
        w_wr_level  = w_car_match[CAPACITY] + CNT_W'(1);
    end

    // fresh token into the first cell
    assign w_car_valid[0]      = r_launch;
    assign w_car_match[0]      = '0;
    assign w_car_best_level[0] = '0;
    assign w_car_best_idx[0]   = '0;
    assign w_car_best_value[0] = '0;

    // row of entry cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_BITS-1:0] w_next_value;
        logic [CNT_W-1:0]      w_next_level;

        if (g == CAPACITY - 1) begin : g_top
            assign w_next_value = w_value[g];
            assign w_next_level = w_level[g];
        end else begin : g_mid
            assign w_next_value = w_value[g+1];
            assign w_next_level = w_level[g+1];
        end

        mfs_cell #(
            .IDX        (g),
            .CAPACITY   (CAPACITY),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_ctl            (w_ctl),
            .i_count          (r_count),
            .i_sel_idx        (w_sel_idx),
            .i_key            (r_key),
            .i_wr_level       (w_wr_level),
            .i_next_value     (w_next_value),
            .i_next_level     (w_next_level),
            .o_value          (w_value[g]),
            .o_level          (w_level[g]),
            .i_car_valid      (w_car_valid[g]),
            .i_car_match      (w_car_match[g]),
            .i_car_best_level (w_car_best_level[g]),
            .i_car_best_idx   (w_car_best_idx[g]),
            .i_car_best_value (w_car_best_value[g]),
            .o_car_valid      (w_car_valid[g+1]),
            .o_car_match      (w_car_match[g+1]),
            .o_car_best_level (w_car_best_level[g+1]),
            .o_car_best_idx   (w_car_best_idx[g+1]),
            .o_car_best_value (w_car_best_value[g+1])
        );
    end

    // sequencer state and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_op     <= OP_PUSH;
            r_launch <= 1'b0;
            r_done   <= 1'b0;
            r_popped <= '0;
            r_status <= ST_PUSHED;
        end else begin
            r_launch <= 1'b0;
            r_done   <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op  <= t_opcode'(i_opcode);
                        r_key <= w_push_key;
                        if ((i_opcode == OP_PUSH) && w_full) begin
                            r_done   <= 1'b1;
                            r_popped <= '0;
                            r_status <= ST_FULL;
                        end else if ((i_opcode == OP_POP) && w_empty) begin
                            r_done   <= 1'b1;
                            r_popped <= '0;
                            r_status <= ST_EMPTY;
                        end else begin
                            r_launch <= 1'b1;
                            r_state  <= S_SWEEP;
                        end
                    end
                end
                S_SWEEP: begin
                    if (w_sweep_done) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                        if (r_op == OP_PUSH) begin
                            r_count  <= r_count + CNT_W'(1);
                            r_popped <= '0;
                            r_status <= ST_PUSHED;
                        end else begin
                            r_count  <= r_count - CNT_W'(1);
                            r_popped <= w_pop_ext[DATA_W-1:0];
                            r_status <= ST_POPPED;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_popped_value = r_popped;
    assign o_status       = r_status;

endmodule
